@@ hdl/assembly_source_tokenizer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the assembly source tokenizer
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define AST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// Assembly source tokenizer package
// Shared widths, codes, token record types and character class helpers.
// ----------------------------------------------------------------------------
package ast_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 16;
	localparam int LEN_BITS    = 16;
	localparam int VAL_BITS    = 31;
	localparam int KIND_BITS   = 3;
	localparam int ERR_BITS    = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	localparam int TDATA_IN_BITS  = 8;
	localparam int FIELD_BITS     = KIND_BITS + VAL_BITS + ERR_BITS + 2 * LINE_BITS
		+ OFFSET_BITS + LEN_BITS;
	localparam int TDATA_OUT_BITS = ((FIELD_BITS + 7) / 8) * 8;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
	localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;
	localparam logic [VAL_BITS+3:0]    VAL_MAX  = {4'b0, {VAL_BITS{1'b1}}};

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_G  = 8'h47;
	localparam logic [15:0] NAME_PC = 16'h5043;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_DEC,
		MODE_ZERO,
		MODE_HEX,
		MODE_IDENT,
		MODE_HALT
	} lex_mode_t;

	localparam logic [KIND_BITS-1:0] KIND_IDENT   = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_REG     = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_LITERAL = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_COLON   = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_END     = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_ERROR   = 3'd5;

	localparam logic [ERR_BITS-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_BITS-1:0] ERR_EXP_DIGIT = 3'd1;
	localparam logic [ERR_BITS-1:0] ERR_EXP_X     = 3'd2;
	localparam logic [ERR_BITS-1:0] ERR_TOO_LARGE = 3'd3;
	localparam logic [ERR_BITS-1:0] ERR_BAD_CHAR  = 3'd4;

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [VAL_BITS-1:0]    value;
		logic [ERR_BITS-1:0]    err;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   col;
		logic [OFFSET_BITS-1:0] offset;
		logic [LEN_BITS-1:0]    len;
		logic                   last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
		logic       halted;
	} lex_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= CH_UP_A && c <= 8'h5A);
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd16;
		if (is_digit(c)) begin
			d = c - CH_ZERO;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end else if (c >= CH_UP_A && c <= 8'h46) begin
			d = c - 8'h37;
		end
		return d[4:0];
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

endpackage

@@ hdl/assembly_source_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Assembly source tokenizer
// Scans assembly source one byte per transaction and emits position-tagged
// tokens: identifiers, registers, literals, colons, end markers and errors.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one source byte in s_axis_tdata, or an end
// marker when s_axis_tuser is high. Each output transaction carries one token
// record in m_axis_tdata; m_axis_tlast marks the final token caused by one
// input transaction. One input can cause zero, one or two tokens.
// An accepted byte is held in the input stage register and scanned from there;
// its tokens are written into the output queue register and offered from it.
// The block takes one byte per cycle as long as the receiver accepts every
// token and each byte yields at most one; a byte that yields two queues both.
// The scan step fires only when the four-entry output queue has room for two
// tokens, which sets the throughput when the receiver stalls: the queue
// fills, the input stage holds its byte and s_axis_tready drops.
// Reset clears the scanner, the counters (line and column to one) and the
// queue. After the first error token no further tokens are produced until
// the next reset, while input bytes are still accepted and dropped.
// ----------------------------------------------------------------------------
`include "assembly_source_tokenizer_assert.svh"

module assembly_source_tokenizer import ast_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [TDATA_IN_BITS-1:0]  s_axis_tdata,   // ch
	input  logic                      s_axis_tuser,   // is_end
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [TDATA_OUT_BITS-1:0] m_axis_tdata,   // token_kind, value, error_code,
	                                                  // start_line, start_col,
	                                                  // start_offset, token_length
	output logic                      m_axis_tlast
);

	logic                     valid_s1;
	logic [7:0]               ch_s1;
	logic                     end_s1;
	logic                     step;
	lex_out_t                 lex_out;

	token_t                   fifo_mem [FIFO_DEPTH];
	logic [PTR_BITS-1:0]      wr_ptr_q;
	logic [PTR_BITS-1:0]      rd_ptr_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic                     pop;
	token_t                   head;

	assign step          = valid_s1 && (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1  <= s_axis_tdata;
			end_s1 <= s_axis_tuser;
		end
	end

	ast_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ch      (ch_s1),
		.is_end  (end_s1),
		.lex_out (lex_out)
	);

	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (lex_out.count != 2'd0) begin
			fifo_mem[wr_ptr_q] <= lex_out.tok0;
		end
		if (lex_out.count == 2'd2) begin
			fifo_mem[wr_ptr_q + 1'b1] <= lex_out.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(lex_out.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_BITS'(lex_out.count) - CNT_BITS'(pop);
		end
	end

	assign head          = fifo_mem[rd_ptr_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = TDATA_OUT_BITS'({head.len, head.offset, head.col, head.line,
		head.err, head.value, head.kind});

	`AST_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_BITS'(FIFO_DEPTH),
		"output queue count exceeds its depth")
	`AST_ASSERT_NXT(a_halt_sticky, lex_out.halted, lex_out.halted,
		"lexer left the halted state without reset")
	`AST_ASSERT_IMP(a_halt_silent, lex_out.halted, lex_out.count == 2'd0,
		"halted lexer produced a token")
	`AST_ASSERT_IMP(a_error_last, m_axis_tvalid && head.kind == KIND_ERROR, m_axis_tlast,
		"error token is not the final token of its transaction")

endmodule

@@ hdl/ast_lexer.sv @@
// ----------------------------------------------------------------------------
// Tokenizer lexer core
// Holds the scanner state and position counters and turns one source byte
// or end marker into up to two tokens, combinationally on each scan step.
// ----------------------------------------------------------------------------
module ast_lexer import ast_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	input  logic       is_end,
	output lex_out_t   lex_out
);

	lex_mode_t              mode_q, mode_d;
	logic [VAL_BITS-1:0]    acc_q, acc_d;
	logic                   ovf_q, ovf_d;
	logic [LEN_BITS-1:0]    len_q, len_d;
	logic [15:0]            head_q, head_d;
	logic                   reg_ok_q, reg_ok_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [LINE_BITS-1:0]   col_q, col_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [LINE_BITS-1:0]   tsl_q, tsl_d;
	logic [LINE_BITS-1:0]   tsc_q, tsc_d;
	logic [OFFSET_BITS-1:0] tso_q, tso_d;

	token_t     fin_tok, sec_tok;
	logic       fin_emit, fin_ok, use_fin, sec_emit;
	logic       extend;
	logic [4:0] hv;
	logic [VAL_BITS+3:0] prod;
	logic [7:0] reg_idx;

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		len_d    = len_q;
		head_d   = head_q;
		reg_ok_d = reg_ok_q;
		line_d   = line_q;
		col_d    = col_q;
		off_d    = off_q;
		tsl_d    = tsl_q;
		tsc_d    = tsc_q;
		tso_d    = tso_q;

		hv      = hex_val(ch);
		reg_idx = head_q[15:8] - CH_UP_A;
		prod    = '0;

		fin_emit       = 1'b0;
		fin_ok         = 1'b1;
		fin_tok        = '0;
		fin_tok.line   = tsl_q;
		fin_tok.col    = tsc_q;
		fin_tok.offset = tso_q;
		case (mode_q)
			MODE_ZERO: begin
				fin_emit       = 1'b1;
				fin_ok         = 1'b0;
				fin_tok.kind   = KIND_ERROR;
				fin_tok.err    = ERR_EXP_X;
				fin_tok.line   = line_q;
				fin_tok.col    = col_q;
				fin_tok.offset = off_q;
			end
			MODE_DEC, MODE_HEX: begin
				fin_emit = 1'b1;
				if (len_q <= ((mode_q == MODE_DEC) ? LEN_BITS'(1) : LEN_BITS'(2))) begin
					fin_ok         = 1'b0;
					fin_tok.kind   = KIND_ERROR;
					fin_tok.err    = ERR_EXP_DIGIT;
					fin_tok.line   = line_q;
					fin_tok.col    = col_q;
					fin_tok.offset = off_q;
				end else if (ovf_q) begin
					fin_ok       = 1'b0;
					fin_tok.kind = KIND_ERROR;
					fin_tok.err  = ERR_TOO_LARGE;
				end else begin
					fin_tok.kind  = KIND_LITERAL;
					fin_tok.value = acc_q;
					fin_tok.len   = len_q;
				end
			end
			MODE_IDENT: begin
				fin_emit    = 1'b1;
				fin_tok.len = len_q;
				if (reg_ok_q && len_q == LEN_BITS'(1) && head_q[15:8] >= CH_UP_A
						&& head_q[15:8] <= CH_UP_G) begin
					fin_tok.kind  = KIND_REG;
					fin_tok.value = VAL_BITS'(reg_idx[2:0]);
				end else if (reg_ok_q && len_q == LEN_BITS'(2) && head_q == NAME_PC) begin
					fin_tok.kind  = KIND_REG;
					fin_tok.value = VAL_BITS'(7);
				end else begin
					fin_tok.kind = KIND_IDENT;
				end
			end
			default: begin
				fin_emit = 1'b0;
			end
		endcase

		case (mode_q)
			MODE_DEC:   extend = is_digit(ch);
			MODE_ZERO:  extend = (ch == CH_LOW_X) || (ch == CH_UP_X);
			MODE_HEX:   extend = !hv[4];
			MODE_IDENT: extend = is_alpha(ch) || is_digit(ch) || ch == CH_UNDER;
			default:    extend = 1'b0;
		endcase

		use_fin        = 1'b0;
		sec_emit       = 1'b0;
		sec_tok        = '0;
		sec_tok.line   = line_q;
		sec_tok.col    = col_q;
		sec_tok.offset = off_q;

		if (step && mode_q != MODE_HALT) begin
			if (is_end) begin
				use_fin      = fin_emit;
				sec_emit     = fin_ok;
				sec_tok.kind = KIND_END;
				mode_d       = fin_ok ? MODE_IDLE : MODE_HALT;
			end else begin
				if (extend) begin
					len_d = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
					case (mode_q)
						MODE_ZERO: begin
							mode_d = MODE_HEX;
						end
						MODE_DEC, MODE_HEX: begin
							if (mode_q == MODE_DEC) begin
								prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
									+ (VAL_BITS+4)'(ch - CH_ZERO);
							end else begin
								prod = {acc_q, 4'b0000} + (VAL_BITS+4)'(hv[3:0]);
							end
							if (!ovf_q) begin
								if (prod > VAL_MAX) begin
									ovf_d = 1'b1;
								end else begin
									acc_d = prod[VAL_BITS-1:0];
								end
							end
						end
						default: begin
							if (len_q == LEN_BITS'(1)) begin
								head_d = {head_q[15:8], upper(ch)};
							end else begin
								reg_ok_d = 1'b0;
							end
						end
					endcase
				end else begin
					use_fin = fin_emit;
					if (!fin_ok) begin
						mode_d = MODE_HALT;
					end else begin
						mode_d = MODE_IDLE;
						if (!(is_space(ch) || ch == CH_COMMA)) begin
							tsl_d = line_q;
							tsc_d = col_q;
							tso_d = off_q;
							acc_d = '0;
							ovf_d = 1'b0;
							len_d = LEN_BITS'(1);
							if (ch == CH_HASH) begin
								mode_d = MODE_DEC;
							end else if (ch == CH_ZERO) begin
								mode_d = MODE_ZERO;
							end else if (is_alpha(ch) || ch == CH_DOT || ch == CH_UNDER) begin
								mode_d   = MODE_IDENT;
								head_d   = {upper(ch), 8'h00};
								reg_ok_d = 1'b1;
							end else if (ch == CH_COLON) begin
								sec_emit     = 1'b1;
								sec_tok.kind = KIND_COLON;
								sec_tok.len  = LEN_BITS'(1);
							end else begin
								sec_emit     = 1'b1;
								sec_tok.kind = KIND_ERROR;
								sec_tok.err  = ERR_BAD_CHAR;
								mode_d       = MODE_HALT;
							end
						end
					end
				end
				off_d = (off_q == OFF_MAX) ? off_q : off_q + 1'b1;
				if (ch == CH_NL) begin
					line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
					col_d  = LINE_BITS'(1);
				end else begin
					col_d = (col_q == LINE_MAX) ? col_q : col_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		lex_out        = '0;
		lex_out.halted = (mode_q == MODE_HALT);
		if (use_fin) begin
			lex_out.tok0      = fin_tok;
			lex_out.tok1      = sec_tok;
			lex_out.tok0.last = !sec_emit;
			lex_out.tok1.last = 1'b1;
			lex_out.count     = sec_emit ? 2'd2 : 2'd1;
		end else begin
			lex_out.tok0      = sec_tok;
			lex_out.tok0.last = 1'b1;
			lex_out.count     = sec_emit ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			len_q    <= '0;
			head_q   <= '0;
			reg_ok_q <= 1'b0;
			line_q   <= LINE_BITS'(1);
			col_q    <= LINE_BITS'(1);
			off_q    <= '0;
			tsl_q    <= LINE_BITS'(1);
			tsc_q    <= LINE_BITS'(1);
			tso_q    <= '0;
		end else begin
			mode_q   <= mode_d;
			acc_q    <= acc_d;
			ovf_q    <= ovf_d;
			len_q    <= len_d;
			head_q   <= head_d;
			reg_ok_q <= reg_ok_d;
			line_q   <= line_d;
			col_q    <= col_d;
			off_q    <= off_d;
			tsl_q    <= tsl_d;
			tsc_q    <= tsc_d;
			tso_q    <= tso_d;
		end
	end

endmodule
